// ===== rtl/tmfw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfw_pkg
// Shared types, constants and letter decoding for the trie word counter.
// ----------------------------------------------------------------------------
package tmfw_pkg;

	// default sizes
	localparam int NODES_DEF        = 1024;
	localparam int MAX_WORD_LEN_DEF = 32;

	// fixed field widths
	localparam int SLOTS    = 52;
	localparam int LETTER_W = 7;
	localparam int COUNT_W  = 32;
	localparam int SLOT_W   = 6;

	// trie controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHILD,
		S_CHECK,
		S_COUNT,
		S_RWAIT,
		S_WALK
	} trie_state_t;

	// report emitter states
	typedef enum logic [1:0] {
		E_IDLE,
		E_READ,
		E_SHOW
	} emit_state_t;

	// controller to emitter control
	typedef struct packed {
		logic wr_en;
		logic start;
		logic empty;
	} emit_ctl_t;

	// letter test: A-Z or a-z
	function automatic logic is_letter(input logic [7:0] c);
		logic r;
		r = (c inside {[8'd65:8'd90]}) || (c inside {[8'd97:8'd122]});
		return r;
	endfunction

	// child slot of a letter: A-Z -> 0..25, a-z -> 26..51
	function automatic logic [SLOT_W-1:0] letter_slot(input logic [7:0] c);
		logic [7:0] d;
		if (c inside {[8'd65:8'd90]}) begin
			d = c - 8'd65;
		end else begin
			d = c - 8'd71;
		end
		return d[SLOT_W-1:0];
	endfunction

endpackage

// ===== rtl/tmfw_child_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfw_child_mem
// Child pointer table, one entry per node and letter slot, registered read.
// ----------------------------------------------------------------------------
module tmfw_child_mem
	import tmfw_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	localparam int NW = $clog2(NODES),
	localparam int DEPTH = NODES * SLOTS,
	localparam int CW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [CW-1:0] rd_addr,
	output logic [NW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_addr,
	input  logic [NW-1:0] wr_data
);

	logic [NW-1:0] mem [DEPTH];
	logic [NW-1:0] rd_q;

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/tmfw_node_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfw_node_mem
// Node records: parent index, letter and word count, registered read.
// ----------------------------------------------------------------------------
module tmfw_node_mem
	import tmfw_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	localparam int NW = $clog2(NODES),
	localparam int REC_W = NW + LETTER_W + COUNT_W
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [NW-1:0]    rd_addr,
	output logic [REC_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [NW-1:0]    wr_addr,
	input  logic [REC_W-1:0] wr_data
);

	logic [REC_W-1:0] mem [NODES];
	logic [REC_W-1:0] rd_q;

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/tmfw_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfw_emitter
// Reverse buffer for the parent walk and output stage that plays the word
// back first letter to last.
// ----------------------------------------------------------------------------
module tmfw_emitter
	import tmfw_pkg::*;
#(
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
	localparam int DW = $clog2(MAX_WORD_LEN + 1),
	localparam int IW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  emit_ctl_t           ctl,
	input  logic [IW-1:0]       wr_idx,
	input  logic [LETTER_W-1:0] wr_letter,
	input  logic [DW-1:0]       len,
	output logic                idle,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LETTER_W-1:0] out_char,
	output logic                last,
	output logic                empty_res
);

	logic [LETTER_W-1:0] buf_mem [MAX_WORD_LEN];
	logic [LETTER_W-1:0] rd_q;
	logic                rd_en;

	emit_state_t   state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic          empty_q, empty_d;
	logic [DW-1:0] len_m1;

	// reverse buffer, written by the walk, read back in reverse
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			buf_mem[wr_idx] <= wr_letter;
		end
		if (rd_en) begin
			rd_q <= buf_mem[idx_q];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			idx_q   <= '0;
			empty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			empty_q <= empty_d;
		end
	end

	assign len_m1 = len - 1'b1;

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		empty_d   = empty_q;
		rd_en     = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			E_IDLE: begin
				if (ctl.start) begin
					if (ctl.empty) begin
						empty_d = 1'b1;
						state_d = E_SHOW;
					end else begin
						empty_d = 1'b0;
						idx_d   = len_m1[IW-1:0];
						state_d = E_READ;
					end
				end
			end
			E_READ: begin
				rd_en   = 1'b1;
				state_d = E_SHOW;
			end
			E_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (empty_q || idx_q == '0) begin
						state_d = E_IDLE;
					end else begin
						idx_d   = idx_q - 1'b1;
						state_d = E_READ;
					end
				end
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	assign idle      = (state_q == E_IDLE);
	assign out_char  = empty_q ? '0 : rd_q;
	assign last      = empty_q || (idx_q == '0);
	assign empty_res = empty_q;

	// a new report only starts once the previous one is fully delivered
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == E_IDLE)
		else $error("report started while emitter busy");

	// the walk never overwrites letters that are still being played back
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> state_q == E_IDLE)
		else $error("reverse buffer written while emitting");

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(last)
			&& $stable(empty_res)))
		else $error("result changed while stalled");

endmodule

// ===== rtl/trie_most_frequent_word.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_most_frequent_word
// Builds a trie of case-sensitive words from a byte stream, counts each
// finished word at its end node and reports the first word to reach the
// highest count.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, action, char_code    | into block
//  out     | out_valid, out_ready, out_char, last,    | out of block
//          | empty_res                                |
//
//  letter: a new node follows the child table read; an existing child entry has to be
//    confirmed against its node record (child table then node memory port)
//  word end: count read-modify-write on the node memory, skipped if nothing is
//    counted; a report walks the parents one letter at a time on the node memory,
//    then shows each result, read from the reverse buffer, until it is taken
//  reset: no clearing pass; child entries are trusted only if the node they
//    name exists and records this parent and letter
//  a report waits until the previous report's results are all taken
// ----------------------------------------------------------------------------
module trie_most_frequent_word
	import tmfw_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [7:0]          char_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LETTER_W-1:0] out_char,
	output logic                last,
	output logic                empty_res
);

	localparam int NW    = $clog2(NODES);
	localparam int CW    = $clog2(NODES * SLOTS);
	localparam int REC_W = NW + LETTER_W + COUNT_W;
	localparam int DW    = $clog2(MAX_WORD_LEN + 1);
	localparam int IW    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

	// control registers
	trie_state_t         state_q, state_d;
	logic [NW-1:0]       cur_q, cur_d;
	logic [DW-1:0]       depth_q, depth_d;
	logic                dropped_q, dropped_d;
	logic [NW-1:0]       used_q, used_d;
	logic [NW-1:0]       best_node_q, best_node_d;
	logic [COUNT_W-1:0]  best_cnt_q, best_cnt_d;
	logic [DW-1:0]       walk_len_q, walk_len_d;

	// payload registers
	logic [LETTER_W-1:0] char_q;
	logic [CW-1:0]       addr_q;
	logic [NW-1:0]       cand_q;

	// memory ports
	logic                child_rd_en, child_wr_en;
	logic [CW-1:0]       child_rd_addr, child_wr_addr;
	logic [NW-1:0]       child_rd_data, child_wr_data;
	logic                node_rd_en, node_wr_en;
	logic [NW-1:0]       node_rd_addr, node_wr_addr;
	logic [REC_W-1:0]    node_rd_data, node_wr_data;

	// emitter link
	emit_ctl_t           emit_ctl;
	logic [IW-1:0]       emit_wr_idx;
	logic [DW-1:0]       emit_len;
	logic                emit_idle;

	// decode and helpers
	logic                accept;
	logic                in_letter;
	logic [SLOT_W-1:0]   in_slot;
	logic [CW-1:0]       in_addr;
	logic [NW-1:0]       rec_parent;
	logic [LETTER_W-1:0] rec_letter;
	logic [COUNT_W-1:0]  rec_count, cnt_inc;
	logic [NW-1:0]       new_node;
	logic                pool_full;
	logic                cand_ok;
	logic [DW-1:0]       walk_next;
	logic                do_create;

	assign accept    = in_valid && in_ready;
	assign in_letter = is_letter(char_code);
	assign in_slot   = letter_slot(char_code);
	// cur * 52 + slot as shifts and adds
	assign in_addr   = CW'({cur_q, 5'b0}) + CW'({cur_q, 4'b0}) + CW'({cur_q, 2'b0})
		+ CW'(in_slot);

	assign rec_parent = node_rd_data[REC_W-1 -: NW];
	assign rec_letter = node_rd_data[COUNT_W +: LETTER_W];
	assign rec_count  = node_rd_data[COUNT_W-1:0];
	assign cnt_inc    = (rec_count == '1) ? rec_count : rec_count + 1'b1;
	assign new_node   = used_q + 1'b1;
	assign pool_full  = (used_q == NW'(NODES - 1));
	assign cand_ok    = (child_rd_data != '0) && (child_rd_data <= used_q);
	assign walk_next  = walk_len_q + 1'b1;

	assign in_ready    = (state_q == S_IDLE);
	assign emit_wr_idx = walk_len_q[IW-1:0];

	// control register update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			depth_q     <= '0;
			dropped_q   <= 1'b0;
			used_q      <= '0;
			best_node_q <= '0;
			best_cnt_q  <= '0;
			walk_len_q  <= '0;
		end else begin
			state_q     <= state_d;
			cur_q       <= cur_d;
			depth_q     <= depth_d;
			dropped_q   <= dropped_d;
			used_q      <= used_d;
			best_node_q <= best_node_d;
			best_cnt_q  <= best_cnt_d;
			walk_len_q  <= walk_len_d;
		end
	end

	// payload capture for the letter in flight
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			char_q <= char_code[LETTER_W-1:0];
			addr_q <= in_addr;
		end
		if (state_q == S_CHILD) begin
			cand_q <= child_rd_data;
		end
	end

	// next state, memory accesses and emitter control
	always_comb begin
		state_d       = state_q;
		cur_d         = cur_q;
		depth_d       = depth_q;
		dropped_d     = dropped_q;
		used_d        = used_q;
		best_node_d   = best_node_q;
		best_cnt_d    = best_cnt_q;
		walk_len_d    = walk_len_q;
		child_rd_en   = 1'b0;
		child_rd_addr = in_addr;
		child_wr_en   = 1'b0;
		child_wr_addr = addr_q;
		child_wr_data = new_node;
		node_rd_en    = 1'b0;
		node_rd_addr  = cur_q;
		node_wr_en    = 1'b0;
		node_wr_addr  = cur_q;
		node_wr_data  = {rec_parent, rec_letter, cnt_inc};
		emit_ctl      = '0;
		emit_len      = walk_next;
		do_create     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action) begin
						state_d = S_RWAIT;
					end else if (in_letter) begin
						// extend the word unless it is already dropped
						if (!dropped_q) begin
							if (depth_q == DW'(MAX_WORD_LEN)) begin
								dropped_d = 1'b1;
							end else begin
								child_rd_en = 1'b1;
								state_d     = S_CHILD;
							end
						end
					end else if (!dropped_q && cur_q != '0) begin
						// close the word: fetch its count
						node_rd_en = 1'b1;
						state_d    = S_COUNT;
					end else begin
						cur_d     = '0;
						depth_d   = '0;
						dropped_d = 1'b0;
					end
				end
			end
			S_CHILD: begin
				// confirm a candidate child against its node record
				if (cand_ok) begin
					node_rd_en   = 1'b1;
					node_rd_addr = child_rd_data;
					state_d      = S_CHECK;
				end else begin
					do_create = 1'b1;
				end
			end
			S_CHECK: begin
				if (rec_parent == cur_q && rec_letter == char_q) begin
					cur_d   = cand_q;
					depth_d = depth_q + 1'b1;
					state_d = S_IDLE;
				end else begin
					do_create = 1'b1;
				end
			end
			S_COUNT: begin
				// saturating count update and best word tracking
				node_wr_en = 1'b1;
				if (cnt_inc > best_cnt_q) begin
					best_cnt_d  = cnt_inc;
					best_node_d = cur_q;
				end
				cur_d     = '0;
				depth_d   = '0;
				dropped_d = 1'b0;
				state_d   = S_IDLE;
			end
			S_RWAIT: begin
				if (emit_idle) begin
					if (best_node_q == '0) begin
						emit_ctl.start = 1'b1;
						emit_ctl.empty = 1'b1;
						state_d        = S_IDLE;
					end else begin
						node_rd_en   = 1'b1;
						node_rd_addr = best_node_q;
						walk_len_d   = '0;
						state_d      = S_WALK;
					end
				end
			end
			S_WALK: begin
				// one parent step per cycle, letters stored last first
				emit_ctl.wr_en = 1'b1;
				if (rec_parent != '0 && walk_next < DW'(MAX_WORD_LEN)) begin
					node_rd_en   = 1'b1;
					node_rd_addr = rec_parent;
					walk_len_d   = walk_next;
				end else begin
					emit_ctl.start = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// new node for the current letter, or drop the word on a full pool
		if (do_create) begin
			state_d = S_IDLE;
			if (pool_full) begin
				dropped_d = 1'b1;
			end else begin
				child_wr_en  = 1'b1;
				node_wr_en   = 1'b1;
				node_wr_addr = new_node;
				node_wr_data = {cur_q, char_q, {COUNT_W{1'b0}}};
				used_d       = new_node;
				cur_d        = new_node;
				depth_d      = depth_q + 1'b1;
			end
		end
	end

	tmfw_child_mem #(
		.NODES(NODES)
	) u_child_mem (
		.clk(clk),
		.rd_en(child_rd_en),
		.rd_addr(child_rd_addr),
		.rd_data(child_rd_data),
		.wr_en(child_wr_en),
		.wr_addr(child_wr_addr),
		.wr_data(child_wr_data)
	);

	tmfw_node_mem #(
		.NODES(NODES)
	) u_node_mem (
		.clk(clk),
		.rd_en(node_rd_en),
		.rd_addr(node_rd_addr),
		.rd_data(node_rd_data),
		.wr_en(node_wr_en),
		.wr_addr(node_wr_addr),
		.wr_data(node_wr_data)
	);

	tmfw_emitter #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(emit_ctl),
		.wr_idx(emit_wr_idx),
		.wr_letter(rec_letter),
		.len(emit_len),
		.idle(emit_idle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.last(last),
		.empty_res(empty_res)
	);

	// the pool never hands out an index beyond the last one
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= NW'(NODES - 1))
		else $error("node pool overrun");

	// word depth stays within the maximum length
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_WORD_LEN))
		else $error("word depth overrun");

	// a best word exists exactly when a count has been recorded
	a_best_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(best_node_q != '0) == (best_cnt_q != '0))
		else $error("best node and best count disagree");

	// a new child pointer always comes with the record of that node
	a_create_pair: assert property (@(posedge clk) disable iff (!arst_n)
		child_wr_en |-> (node_wr_en && node_wr_addr == child_wr_data))
		else $error("child pointer written without its node record");

	// the best word always names an allocated node
	a_best_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		best_node_q <= used_q)
		else $error("best node not allocated");

endmodule
